@@ hdl/ccs_pkg.sv @@
// Shared types and constants for the C block comment stripper.
// Holds the scan state encoding, character codes and the queue entry type.
// No dependencies.
package ccs_pkg;

   // Character codes the scanner looks for
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Scanner state
   typedef enum logic [2:0] {
      SCAN_NORMAL  = 3'd0,
      SCAN_SLASH   = 3'd1,
      SCAN_COMMENT = 3'd2,
      SCAN_CSTAR   = 3'd3,
      SCAN_QUOTE   = 3'd4,
      SCAN_QESC    = 3'd5
   } scan_mode_type;

   // One queued command: pair means a held-back slash goes out before ch
   typedef struct packed {
      logic       pair;
      logic [7:0] ch;
   } cmd_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ hdl/ccs_if.sv @@
// Valid/ready channel interfaces for the comment stripper.
// Depends on nothing; payload widths follow the byte stream.
interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface

@@ hdl/c_block_comment_stripper.sv @@
// Top level of the C block comment stripper.
// Depends on ccs_pkg, ccs_if, ccs_front, ccs_queue and ccs_back.
//
//  Channel  Dir  Payload             Transfer
//  req_ch   in   in_char[7:0]        valid && ready
//  rsp_ch   out  out_char[7:0], last valid && ready
//
// An item is classified in the cycle it is accepted; its first result passes
// through the command queue and the output register to rsp_ch when the back end is free.
// Items with one result sustain one item per cycle while rsp_ch is ready; a slash
// followed by a non-star, non-slash byte gives two results, the held slash and then
// the byte, which leave the output register one after the other.
// Items inside a comment produce nothing, but still wait while the queue is full.
// Reset (synchronous) returns the scanner to normal text and empties the queue.
// req_ch.ready drops only when the command queue is full.
module c_block_comment_stripper #(
   parameter int QueueDepth = ccs_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   ccs_req_if.sink   req_ch,
   ccs_rsp_if.source rsp_ch
);

   ccs_pkg::q_status_type q_status;
   ccs_pkg::cmd_type      push_cmd;
   ccs_pkg::cmd_type      head;
   logic                  push;
   logic                  pop;

   ccs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_in_char (req_ch.in_char),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ccs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   ccs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_out_char (rsp_ch.out_char),
      .rsp_last     (rsp_ch.last)
   );

endmodule

@@ hdl/ccs_front.sv @@
// Front end: accepts source bytes and runs the comment scanner.
// Pushes one command per item that yields output. Uses ccs_pkg.
module ccs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_char,
   input  ccs_pkg::q_status_type q_status,
   output logic                  push,
   output ccs_pkg::cmd_type      push_cmd
);

   ccs_pkg::scan_mode_type scan_ff, scan_in;
   logic                   dquote_ff, dquote_in;
   logic                   accept;
   logic [7:0]             closer;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign closer    = dquote_ff ? ccs_pkg::CH_DQUOTE : ccs_pkg::CH_SQUOTE;

   // Next scanner state
   always_comb begin
      scan_in   = scan_ff;
      dquote_in = dquote_ff;
      if (accept) begin
         case (scan_ff)
            ccs_pkg::SCAN_SLASH: begin
               if (req_in_char == ccs_pkg::CH_STAR) begin
                  scan_in = ccs_pkg::SCAN_COMMENT;
               end else if (req_in_char != ccs_pkg::CH_SLASH) begin
                  scan_in = ccs_pkg::SCAN_NORMAL;
               end
            end
            ccs_pkg::SCAN_COMMENT: begin
               if (req_in_char == ccs_pkg::CH_STAR) begin
                  scan_in = ccs_pkg::SCAN_CSTAR;
               end
            end
            ccs_pkg::SCAN_CSTAR: begin
               if (req_in_char == ccs_pkg::CH_SLASH) begin
                  scan_in = ccs_pkg::SCAN_NORMAL;
               end else if (req_in_char != ccs_pkg::CH_STAR) begin
                  scan_in = ccs_pkg::SCAN_COMMENT;
               end
            end
            ccs_pkg::SCAN_QUOTE: begin
               if (req_in_char == closer) begin
                  scan_in = ccs_pkg::SCAN_NORMAL;
               end else if (req_in_char == ccs_pkg::CH_BACKSLASH) begin
                  scan_in = ccs_pkg::SCAN_QESC;
               end
            end
            ccs_pkg::SCAN_QESC: begin
               scan_in = ccs_pkg::SCAN_QUOTE;
            end
            default: begin
               scan_in = ccs_pkg::SCAN_NORMAL;
               if (req_in_char == ccs_pkg::CH_SLASH) begin
                  scan_in = ccs_pkg::SCAN_SLASH;
               end else if (req_in_char == ccs_pkg::CH_SQUOTE ||
                            req_in_char == ccs_pkg::CH_DQUOTE) begin
                  scan_in   = ccs_pkg::SCAN_QUOTE;
                  dquote_in = (req_in_char == ccs_pkg::CH_DQUOTE);
               end
            end
         endcase
      end
   end

   // Command for the back end
   always_comb begin
      push          = 1'b0;
      push_cmd.pair = 1'b0;
      push_cmd.ch   = req_in_char;
      case (scan_ff)
         ccs_pkg::SCAN_SLASH: begin
            // star opens a comment; otherwise the held slash comes out
            push          = accept && (req_in_char != ccs_pkg::CH_STAR);
            push_cmd.pair = (req_in_char != ccs_pkg::CH_SLASH);
         end
         ccs_pkg::SCAN_COMMENT,
         ccs_pkg::SCAN_CSTAR: begin
            push = 1'b0;
         end
         ccs_pkg::SCAN_QUOTE,
         ccs_pkg::SCAN_QESC: begin
            push = accept;
         end
         default: begin
            push = accept && (req_in_char != ccs_pkg::CH_SLASH);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= ccs_pkg::SCAN_NORMAL;
         dquote_ff <= 1'b0;
      end else begin
         scan_ff   <= scan_in;
         dquote_ff <= dquote_in;
      end
   end

   // Nothing comes out of a comment
   a_no_push_in_comment: assert property (@(posedge clock) disable iff (reset)
      (scan_ff == ccs_pkg::SCAN_COMMENT || scan_ff == ccs_pkg::SCAN_CSTAR) |-> !push)
      else $error("front pushed a command inside a comment");

   // A slash-star pair always enters a comment
   a_open_comment: assert property (@(posedge clock) disable iff (reset)
      (accept && scan_ff == ccs_pkg::SCAN_SLASH && req_in_char == ccs_pkg::CH_STAR)
      |=> scan_ff == ccs_pkg::SCAN_COMMENT)
      else $error("slash-star did not open a comment");

   // A pair command only follows a pending slash
   a_pair_source: assert property (@(posedge clock) disable iff (reset)
      (push && push_cmd.pair) |-> scan_ff == ccs_pkg::SCAN_SLASH)
      else $error("pair command outside slash pending");

endmodule

@@ hdl/ccs_queue.sv @@
// Short command queue between the scanner front and the output back end.
// Register array with read and write pointers. Uses ccs_pkg.
module ccs_queue #(
   parameter int Depth = ccs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ccs_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output ccs_pkg::cmd_type      head,
   output ccs_pkg::q_status_type q_status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   ccs_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign q_status.full  = (count_ff == CntW'(Depth));
   assign q_status.empty = (count_ff == '0);
   assign head           = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count out of range");

endmodule

@@ hdl/ccs_back.sv @@
// Back end: turns queued commands into output bytes, one per cycle while rsp_ready allows.
// A pair command sends the held slash first, then its byte. Uses ccs_pkg.
module ccs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ccs_pkg::cmd_type      head,
   input  ccs_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       half_ff, half_in;
   logic       load;

   // Output register frees up when empty or being taken
   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      half_in  = half_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head.pair && !half_ff) begin
               // held slash goes first, byte follows next
               char_in = ccs_pkg::CH_SLASH;
               last_in = 1'b0;
               half_in = 1'b1;
            end else begin
               char_in = head.ch;
               last_in = 1'b1;
               half_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

   // A non-final result is always the held slash, with its byte still queued
   a_first_half: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (char_ff == ccs_pkg::CH_SLASH && half_ff))
      else $error("non-final result is not a pending slash");

   // Second half is owed to the head entry, which must still be there
   a_half_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (!q_status.empty && head.pair))
      else $error("second half pending without its entry");

   // A stalled result holds steady
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(char_ff) && $stable(last_ff)))
      else $error("stalled result changed");

endmodule

@@ sim/ccs_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the C block comment stripper: watches both channels, models
// the scanner byte by byte and compares every output item. Depends on ccs_pkg.
module ccs_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_char,
   input  logic       rsp_last,
   input  logic       end_of_test,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);

   // One expected output item
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_byte_type;

   out_byte_type           expected_bytes[$];
   out_byte_type           oldest;
   ccs_pkg::scan_mode_type mode;
   logic                   in_dquote;
   logic                   leftover_checked;
   int                     errors   = 0;
   int                     n_pend   = 0;
   int                     n_chk    = 0;

   assign fail_count    = errors;
   assign pending_count = n_pend;
   assign checked_count = n_chk;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic expect_byte(input logic [7:0] ch, input logic last);
      out_byte_type e;
      e.ch   = ch;
      e.last = last;
      expected_bytes.push_back(e);
   endtask

   // Scanner model: advance on one input byte and queue what it emits
   task automatic filter_byte(input logic [7:0] c);
      logic [7:0] closer;
      closer = in_dquote ? ccs_pkg::CH_DQUOTE : ccs_pkg::CH_SQUOTE;
      case (mode)
         ccs_pkg::SCAN_SLASH: begin
            if (c == ccs_pkg::CH_STAR) begin
               mode = ccs_pkg::SCAN_COMMENT;
            end else if (c == ccs_pkg::CH_SLASH) begin
               // slash-slash: one slash out, the second stays held
               expect_byte(ccs_pkg::CH_SLASH, 1'b1);
            end else begin
               // held slash, then this byte unexamined
               mode = ccs_pkg::SCAN_NORMAL;
               expect_byte(ccs_pkg::CH_SLASH, 1'b0);
               expect_byte(c, 1'b1);
            end
         end
         ccs_pkg::SCAN_COMMENT: begin
            if (c == ccs_pkg::CH_STAR) mode = ccs_pkg::SCAN_CSTAR;
         end
         ccs_pkg::SCAN_CSTAR: begin
            if (c == ccs_pkg::CH_SLASH) mode = ccs_pkg::SCAN_NORMAL;
            else if (c != ccs_pkg::CH_STAR) mode = ccs_pkg::SCAN_COMMENT;
         end
         ccs_pkg::SCAN_QUOTE: begin
            if (c == closer) mode = ccs_pkg::SCAN_NORMAL;
            else if (c == ccs_pkg::CH_BACKSLASH) mode = ccs_pkg::SCAN_QESC;
            expect_byte(c, 1'b1);
         end
         ccs_pkg::SCAN_QESC: begin
            mode = ccs_pkg::SCAN_QUOTE;
            expect_byte(c, 1'b1);
         end
         default: begin
            mode = ccs_pkg::SCAN_NORMAL;
            if (c == ccs_pkg::CH_SLASH) begin
               mode = ccs_pkg::SCAN_SLASH;
            end else begin
               if (c == ccs_pkg::CH_SQUOTE || c == ccs_pkg::CH_DQUOTE) begin
                  in_dquote = (c == ccs_pkg::CH_DQUOTE);
                  mode      = ccs_pkg::SCAN_QUOTE;
               end
               expect_byte(c, 1'b1);
            end
         end
      endcase
   endtask

   // Results first: an item accepted at this edge cannot answer at the same edge
   always @(posedge clock) begin
      if (reset) begin
         mode             = ccs_pkg::SCAN_NORMAL;
         in_dquote        = 1'b0;
         leftover_checked = 1'b0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected output item %h last %b",
                                         rsp_char, rsp_last));
            end else begin
               oldest = expected_bytes.pop_front();
               n_chk++;
               if (rsp_char !== oldest.ch) begin
                  report_mismatch($sformatf("out_char %h, expected %h",
                                            rsp_char, oldest.ch));
               end
               if (rsp_last !== oldest.last) begin
                  report_mismatch($sformatf("last %b, expected %b for byte %h",
                                            rsp_last, oldest.last, oldest.ch));
               end
            end
         end
         if (req_valid && req_ready) filter_byte(req_char);
         if (end_of_test && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_bytes.size() != 0) begin
               report_mismatch($sformatf("%0d expected items never arrived",
                                         expected_bytes.size()));
            end
         end
      end
      n_pend = expected_bytes.size();
   end

endmodule

@@ sim/c_block_comment_stripper_tb.sv @@
`timescale 1ns / 1ps
// Top of the comment stripper testbench: clock, reset, byte stimulus and the
// verdict. Depends on ccs_pkg, ccs_if, the block and ccs_scoreboard.
module c_block_comment_stripper_tb;

   logic clock;
   logic reset;
   logic end_of_test;
   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   n_sent;
   int   n_directed;

   ccs_req_if req_ch ();
   ccs_rsp_if rsp_ch ();

   c_block_comment_stripper u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ccs_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_char      (req_ch.in_char),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_char      (rsp_ch.out_char),
      .rsp_last      (rsp_ch.last),
      .end_of_test   (end_of_test),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #2000000;
      $display("c_block_comment_stripper test failed");
      $finish;
   end

   // Receiver: random stalls, changed at the falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one item, with random idle cycles ahead of it
   task automatic send_item(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid   <= 1'b0;
         req_ch.in_char <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_char <= b;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
      @(negedge clock);
   endtask

   // Mostly the bytes the scanner cares about, otherwise anything
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return ccs_pkg::CH_SLASH;
         1: return ccs_pkg::CH_STAR;
         2: return ccs_pkg::CH_SQUOTE;
         3: return ccs_pkg::CH_DQUOTE;
         4: return ccs_pkg::CH_BACKSLASH;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One piece of source text: comment, literal, slash runs, plain text or noise
   task automatic send_fragment();
      int         n;
      logic [7:0] q;
      case ($urandom_range(9))
         0, 1: send_item(8'($urandom_range(255)));
         2, 3: begin
            send_item(ccs_pkg::CH_SLASH);
            send_item(ccs_pkg::CH_STAR);
            n = $urandom_range(6);
            repeat (n) send_item(pick_byte());
            if ($urandom_range(2) == 0) send_item(ccs_pkg::CH_STAR);
            send_item(ccs_pkg::CH_STAR);
            send_item(ccs_pkg::CH_SLASH);
         end
         4, 5: begin
            q = $urandom_range(1) ? ccs_pkg::CH_DQUOTE : ccs_pkg::CH_SQUOTE;
            send_item(q);
            n = $urandom_range(6);
            repeat (n) begin
               if ($urandom_range(3) == 0) send_item(ccs_pkg::CH_BACKSLASH);
               send_item(pick_byte());
            end
            send_item(q);
         end
         6: begin
            send_item(ccs_pkg::CH_SLASH);
            send_item(pick_byte());
         end
         7: begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(ccs_pkg::CH_SLASH);
            send_item(pick_byte());
         end
         default: begin
            n = $urandom_range(1, 5);
            repeat (n) send_item(8'($urandom_range(32, 126)));
         end
      endcase
   endtask

   // Directed text: byte extremes, held slashes, comment corners, quotes
   logic [7:0] directed_bytes[] = '{
      8'h00, 8'hFF,
      // slash runs, quote not opened
      ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_DQUOTE,
      // slash-star-slash stays open
      ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
      // star run then close
      ccs_pkg::CH_STAR, 8'h78, ccs_pkg::CH_STAR, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
      ccs_pkg::CH_SQUOTE, ccs_pkg::CH_BACKSLASH, ccs_pkg::CH_SQUOTE,
      ccs_pkg::CH_DQUOTE, ccs_pkg::CH_SQUOTE,
      ccs_pkg::CH_DQUOTE, 8'h0A, ccs_pkg::CH_BACKSLASH, ccs_pkg::CH_DQUOTE,
      ccs_pkg::CH_SQUOTE, ccs_pkg::CH_DQUOTE,
      ccs_pkg::CH_SLASH, 8'h80
   };

   initial begin
      int goal;
      int wait_cycles;
      reset          = 1'b1;
      end_of_test    = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.in_char = 8'h00;
      send_idle_pct  = 31;
      recv_idle_pct  = 71;
      n_sent         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_bytes[i]) send_item(directed_bytes[i]);
      n_directed = n_sent;

      // Three idle mixes, about a third of the random text each
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
         goal = n_directed + (phase + 1) * 634;
         while (n_sent < goal) send_fragment();
      end
      req_ch.valid <= 1'b0;

      // Drain, then let any trailing work show up
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      if (pending_count != 0) begin
         $display("c_block_comment_stripper test failed");
         $finish;
      end else begin
         repeat (8) @(negedge clock);
         end_of_test <= 1'b1;
         repeat (2) @(negedge clock);
         $display("Covered %0d input items (%0d directed) and checked %0d output items",
                  n_sent, n_directed, checked_count);
         $display("Idle mixes: sender 31/receiver 71, sender 71/receiver 31, no idling");
         if (fail_count == 0) begin
            $display("c_block_comment_stripper test passed");
         end else begin
            $display("c_block_comment_stripper test failed");
         end
         $finish;
      end
   end

endmodule

@@ c_block_comment_stripper.f @@
hdl/ccs_pkg.sv
hdl/ccs_if.sv
hdl/ccs_front.sv
hdl/ccs_queue.sv
hdl/ccs_back.sv
hdl/c_block_comment_stripper.sv
sim/ccs_scoreboard.sv
sim/c_block_comment_stripper_tb.sv
